>>> rtl/lruc_pkg.sv
// ---------------------------------------------------------------------------
// lruc_pkg
// Shared codes, widths and types of the LRU cache with timed expiry.
// ---------------------------------------------------------------------------
package lruc_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 64;
    localparam int TIME_W = 32;
    localparam int STAT_W = 41;
    localparam int OUT_CW = 11;

    localparam logic [2:0] OP_GET    = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_SWEEP  = 3'd3;
    localparam logic [2:0] OP_STAT   = 3'd4;

    localparam int NUM_STATS    = 7;
    localparam int STAT_GET     = 0;
    localparam int STAT_SET     = 1;
    localparam int STAT_HIT     = 2;
    localparam int STAT_MISS    = 3;
    localparam int STAT_DEL     = 4;
    localparam int STAT_PURGED  = 5;
    localparam int STAT_EXPIRED = 6;

    localparam logic [STAT_W-1:0] STAT_MAX   = {STAT_W{1'b1}};
    localparam logic [STAT_W-1:0] STAT_LIMIT = {1'b1, {(STAT_W-1){1'b0}}};

    localparam logic REG_MAX_ENTRIES    = 1'b0;
    localparam logic REG_EXPIRE_TIMEOUT = 1'b1;

    localparam logic [10:0] MAX_ENTRIES_RST = 11'd1000;
    localparam logic [15:0] TIMEOUT_RST     = 16'd60;

    typedef struct packed {
        logic [NUM_STATS-1:0] inc;
        logic [STAT_W-1:0]    amt;
        logic                 chk;
    } stat_upd_t;

endpackage

>>> rtl/lruc_ram.sv
// ---------------------------------------------------------------------------
// lruc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module lruc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/lruc_stats.sv
// ---------------------------------------------------------------------------
// lruc_stats
// Seven saturating statistic counters with a clear-on-overflow check.
// ---------------------------------------------------------------------------
module lruc_stats
    import lruc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  stat_upd_t         upd,
    input  logic [2:0]        rd_idx,
    output logic [STAT_W-1:0] rd_value
);

    logic [STAT_W-1:0] cnt_reg  [NUM_STATS];
    logic [STAT_W-1:0] cnt_next [NUM_STATS];
    logic [STAT_W:0]   sum      [NUM_STATS];
    logic [STAT_W-1:0] amt      [NUM_STATS];
    logic              over;

    always_comb begin
        over = 1'b0;
        for (int i = 0; i < NUM_STATS; i++) begin
            amt[i] = (i == STAT_PURGED || i == STAT_EXPIRED) ? upd.amt : STAT_W'(1);
            sum[i] = {1'b0, cnt_reg[i]} + {1'b0, amt[i]};
            cnt_next[i] = cnt_reg[i];
            if (upd.inc[i]) begin
                // saturate at the top of the range
                cnt_next[i] = sum[i][STAT_W] ? STAT_MAX : sum[i][STAT_W-1:0];
            end
            if (cnt_reg[i] > STAT_LIMIT) begin
                over = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STATS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (upd.chk && over) begin
            for (int i = 0; i < NUM_STATS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_STATS; i++) begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    assign rd_value = (32'(rd_idx) < NUM_STATS) ? cnt_reg[rd_idx] : '0;

endmodule

>>> rtl/lru_cache_with_timed_expiry_unit.sv
// ---------------------------------------------------------------------------
// lru_cache_with_timed_expiry_unit
// Fully associative key/value cache with LRU order and sweep-based expiry.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | s_valid/s_ready, s_opcode .. s_stat_index | in
//   result  | m_valid/m_ready, m_found .. m_stat_value  | out
//   config  | cfg_we, cfg_index, cfg_wdata            | in
//
// Every entry sits in one entry RAM; each pass scans it one entry per cycle.
// Get, set and delete run two passes (a get or delete that misses skips
// the second pass), a sweep three passes plus the rank RAM, and a stat
// read or unknown opcode goes straight to the result.
// After reset a clearing pass writes every entry before the first item.
// A finished result waits in the output register; the next request is
// accepted meanwhile, and a new result waits until that one is taken.
// ---------------------------------------------------------------------------
module lru_cache_with_timed_expiry_unit
    import lruc_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_opcode,
    input  logic [KEY_W-1:0]    s_key_tag,
    input  logic [DATA_W-1:0]   s_data_in,
    input  logic [TIME_W-1:0]   s_now_seconds,
    input  logic [2:0]          s_stat_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found,
    output logic [DATA_W-1:0]   m_data_out,
    output logic [OUT_CW-1:0]   m_entries_now,
    output logic [OUT_CW-1:0]   m_removed_count,
    output logic [STAT_W-1:0]   m_stat_value,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_wdata
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int RW    = AW;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int PCW   = $clog2(CAPACITY + 2);
    localparam int V_LSB = 0;
    localparam int S_LSB = DATA_W;
    localparam int T_LSB = DATA_W + TIME_W;
    localparam int R_LSB = DATA_W + TIME_W + KEY_W;
    localparam int EW    = R_LSB + RW + 1;
    localparam int VLD   = EW - 1;
    localparam int XW    = RW + 1;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_FIND  = 4'd2;
    localparam logic [3:0] ST_UPD   = 4'd3;
    localparam logic [3:0] ST_SWA   = 4'd4;
    localparam logic [3:0] ST_SWB   = 4'd5;
    localparam logic [3:0] ST_SWC   = 4'd6;
    localparam logic [3:0] ST_CHK   = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [PCW-1:0]    cnt_reg, cnt_next;
    logic              s1_v_reg, s1_v_next;
    logic [AW-1:0]     s1_idx_reg, s1_idx_next;
    logic              s2_v_reg, s2_v_next;
    logic [AW-1:0]     s2_idx_reg, s2_idx_next;
    logic [EW-1:0]     s2_word_reg, s2_word_next;

    logic [2:0]        op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] data_reg;
    logic [TIME_W-1:0] now_reg;
    logic [2:0]        sidx_reg;
    logic [10:0]       max_entries_reg;
    logic [15:0]       timeout_reg;

    logic [CW-1:0]     count_reg, count_next;
    logic              hit_reg, hit_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [RW-1:0]     hrank_reg, hrank_next;
    logic [DATA_W-1:0] hval_reg, hval_next;
    logic              evict_reg, evict_next;
    logic [CW-1:0]     cut_reg, cut_next;
    logic              ins_reg, ins_next;
    logic [CW-1:0]     removed_reg, removed_next;
    logic [CW-1:0]     nsurv_reg, nsurv_next;

    logic              m_valid_reg, m_valid_next;
    logic              found_o_reg, found_o_next;
    logic [DATA_W-1:0] dout_o_reg, dout_o_next;
    logic [OUT_CW-1:0] ent_o_reg, ent_o_next;
    logic [OUT_CW-1:0] rem_o_reg, rem_o_next;
    logic [STAT_W-1:0] sval_o_reg, sval_o_next;

    logic              ent_we;
    logic [AW-1:0]     ent_waddr, ent_raddr;
    logic [EW-1:0]     ent_wdata, ent_rdata;
    logic              aux_we;
    logic [AW-1:0]     aux_waddr, aux_raddr;
    logic [XW-1:0]     aux_wdata, aux_rdata;

    stat_upd_t         stat_upd;
    logic [STAT_W-1:0] stat_rd;

    logic              accept;
    logic              pass_end;
    logic              rd_go;
    logic              w_valid;
    logic [RW-1:0]     w_rank;
    logic              match;
    logic              exp_on;
    logic [TIME_W-1:0] cut_time;
    logic [31:0]       max32, lim32, count32, removed32;
    logic [EW-1:0]     nw;

    lruc_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_entry_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    lruc_ram #(.WIDTH(XW), .DEPTH(CAPACITY)) u_rank_ram (
        .aclk  (aclk),
        .we    (aux_we),
        .waddr (aux_waddr),
        .wdata (aux_wdata),
        .raddr (aux_raddr),
        .rdata (aux_rdata)
    );

    lruc_stats u_stats (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .upd      (stat_upd),
        .rd_idx   (sidx_reg),
        .rd_value (stat_rd)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign pass_end = (cnt_reg == PCW'(CAPACITY + 1));
    assign rd_go    = (cnt_reg < PCW'(CAPACITY));
    assign w_valid  = ent_rdata[VLD];
    assign w_rank   = ent_rdata[R_LSB +: RW];
    assign match    = s1_v_reg && w_valid && (ent_rdata[T_LSB +: KEY_W] == key_reg);
    assign exp_on   = (now_reg >= TIME_W'(timeout_reg));
    assign cut_time = now_reg - TIME_W'(timeout_reg);
    assign max32    = 32'(max_entries_reg);
    assign lim32    = (max32 == 32'd0) ? 32'd1 :
                      ((max32 > 32'(CAPACITY)) ? 32'(CAPACITY) : max32);
    assign count32   = 32'(count_reg);
    assign removed32 = 32'(removed_reg);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        s1_v_next    = 1'b0;
        s1_idx_next  = cnt_reg[AW-1:0];
        s2_v_next    = 1'b0;
        s2_idx_next  = s1_idx_reg;
        s2_word_next = ent_rdata;
        count_next   = count_reg;
        hit_next     = hit_reg;
        slot_next    = slot_reg;
        hrank_next   = hrank_reg;
        hval_next    = hval_reg;
        evict_next   = evict_reg;
        cut_next     = cut_reg;
        ins_next     = ins_reg;
        removed_next = removed_reg;
        nsurv_next   = nsurv_reg;
        m_valid_next = m_valid_reg && !m_ready;
        found_o_next = found_o_reg;
        dout_o_next  = dout_o_reg;
        ent_o_next   = ent_o_reg;
        rem_o_next   = rem_o_reg;
        sval_o_next  = sval_o_reg;
        ent_we       = 1'b0;
        ent_waddr    = s1_idx_reg;
        ent_wdata    = ent_rdata;
        ent_raddr    = cnt_reg[AW-1:0];
        aux_we       = 1'b0;
        aux_waddr    = w_rank;
        aux_wdata    = '0;
        aux_raddr    = (state_reg == ST_SWB) ? cnt_reg[AW-1:0] : w_rank;
        stat_upd     = '0;
        nw           = ent_rdata;

        if (state_reg == ST_FIND || state_reg == ST_UPD || state_reg == ST_SWA ||
            state_reg == ST_SWB || state_reg == ST_SWC) begin
            s1_v_next = rd_go;
            cnt_next  = pass_end ? '0 : cnt_reg + PCW'(1);
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ent_we    = 1'b1;
                ent_waddr = cnt_reg[AW-1:0];
                ent_wdata = '0;
                if (cnt_reg == PCW'(CAPACITY - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + PCW'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    hit_next     = 1'b0;
                    ins_next     = 1'b0;
                    removed_next = '0;
                    nsurv_next   = '0;
                    cnt_next     = '0;
                    unique case (s_opcode) inside
                        OP_GET, OP_SET, OP_DELETE: state_next = ST_FIND;
                        OP_SWEEP:                  state_next = ST_SWA;
                        default:                   state_next = ST_DONE;
                    endcase
                end
            end
            ST_FIND: begin
                if (match && !hit_reg) begin
                    hit_next   = 1'b1;
                    slot_next  = s1_idx_reg;
                    hrank_next = w_rank;
                    hval_next  = ent_rdata[V_LSB +: DATA_W];
                end
                if (pass_end) begin
                    evict_next = (count32 >= lim32);
                    cut_next   = CW'(lim32 - 32'd1);
                    unique case (op_reg)
                        OP_GET: begin
                            stat_upd.inc[STAT_GET]  = 1'b1;
                            stat_upd.inc[STAT_HIT]  = hit_reg;
                            stat_upd.inc[STAT_MISS] = !hit_reg;
                            state_next = hit_reg ? ST_UPD : ST_DONE;
                        end
                        OP_SET:  state_next = ST_UPD;
                        default: state_next = hit_reg ? ST_UPD : ST_DONE;
                    endcase
                end
            end
            ST_UPD: begin
                if (s1_v_reg) begin
                    unique case (op_reg)
                        OP_DELETE: begin
                            if (s1_idx_reg == slot_reg) begin
                                nw[VLD] = 1'b0;
                            end else if (w_valid && w_rank > hrank_reg) begin
                                nw[R_LSB +: RW] = w_rank - RW'(1);
                            end
                        end
                        OP_SET: begin
                            if (hit_reg) begin
                                if (s1_idx_reg == slot_reg) begin
                                    nw[R_LSB +: RW]      = '0;
                                    nw[S_LSB +: TIME_W]  = now_reg;
                                    nw[V_LSB +: DATA_W]  = data_reg;
                                end else if (w_valid && w_rank < hrank_reg) begin
                                    nw[R_LSB +: RW] = w_rank + RW'(1);
                                end
                            end else begin
                                if (w_valid && evict_reg && CW'(w_rank) >= cut_reg) begin
                                    // drop from the least recent end
                                    nw[VLD]      = 1'b0;
                                    removed_next = removed_reg + CW'(1);
                                end else if (w_valid) begin
                                    nw[R_LSB +: RW] = w_rank + RW'(1);
                                end
                                if (!nw[VLD] && !ins_reg) begin
                                    nw       = {1'b1, RW'(0), key_reg, now_reg, data_reg};
                                    ins_next = 1'b1;
                                end
                            end
                        end
                        default: begin
                            if (s1_idx_reg == slot_reg) begin
                                nw[R_LSB +: RW] = '0;
                            end else if (w_valid && w_rank < hrank_reg) begin
                                nw[R_LSB +: RW] = w_rank + RW'(1);
                            end
                        end
                    endcase
                    ent_we    = 1'b1;
                    ent_wdata = nw;
                end
                if (pass_end) begin
                    state_next = ST_DONE;
                    unique case (op_reg)
                        OP_SET: begin
                            stat_upd.inc[STAT_SET]    = 1'b1;
                            stat_upd.inc[STAT_PURGED] = 1'b1;
                            stat_upd.amt              = STAT_W'(removed_reg);
                            if (!hit_reg) begin
                                count_next = (evict_reg ? cut_reg : count_reg) + CW'(ins_reg);
                            end
                        end
                        OP_DELETE: begin
                            stat_upd.inc[STAT_DEL] = 1'b1;
                            count_next = count_reg - CW'(1);
                        end
                        default: begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_SWA: begin
                if (s1_v_reg && w_valid) begin
                    aux_we = 1'b1;
                    if (exp_on && ent_rdata[S_LSB +: TIME_W] < cut_time) begin
                        nw[VLD]      = 1'b0;
                        ent_we       = 1'b1;
                        ent_wdata    = nw;
                        removed_next = removed_reg + CW'(1);
                        aux_wdata    = {1'b0, RW'(0)};
                    end else begin
                        aux_wdata = {1'b1, RW'(0)};
                    end
                end
                if (pass_end) begin
                    state_next = ST_SWB;
                end
            end
            ST_SWB: begin
                // walk ranks in order and number the survivors densely
                if (s1_v_reg && CW'(s1_idx_reg) < count_reg) begin
                    aux_we    = 1'b1;
                    aux_waddr = s1_idx_reg;
                    aux_wdata = {aux_rdata[XW-1], nsurv_reg[RW-1:0]};
                    if (aux_rdata[XW-1]) begin
                        nsurv_next = nsurv_reg + CW'(1);
                    end
                end
                if (pass_end) begin
                    state_next = ST_SWC;
                end
            end
            ST_SWC: begin
                s2_v_next = s1_v_reg && w_valid;
                if (s2_v_reg) begin
                    ent_we    = 1'b1;
                    ent_waddr = s2_idx_reg;
                    ent_wdata = s2_word_reg;
                    ent_wdata[R_LSB +: RW] = aux_rdata[RW-1:0];
                end
                if (pass_end) begin
                    count_next                 = nsurv_reg;
                    stat_upd.inc[STAT_EXPIRED] = 1'b1;
                    stat_upd.amt               = STAT_W'(removed_reg);
                    state_next                 = ST_CHK;
                end
            end
            ST_CHK: begin
                stat_upd.chk = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    found_o_next = hit_reg && (op_reg == OP_GET || op_reg == OP_DELETE);
                    dout_o_next  = (hit_reg && op_reg == OP_GET) ? hval_reg : '0;
                    ent_o_next   = count32[OUT_CW-1:0];
                    rem_o_next   = removed32[OUT_CW-1:0];
                    sval_o_next  = (op_reg == OP_STAT) ? stat_rd : '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            cnt_reg         <= '0;
            s1_v_reg        <= 1'b0;
            s2_v_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
            count_reg       <= '0;
            hit_reg         <= 1'b0;
            evict_reg       <= 1'b0;
            ins_reg         <= 1'b0;
            removed_reg     <= '0;
            nsurv_reg       <= '0;
            max_entries_reg <= MAX_ENTRIES_RST;
            timeout_reg     <= TIMEOUT_RST;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            s1_v_reg    <= s1_v_next;
            s2_v_reg    <= s2_v_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            hit_reg     <= hit_next;
            evict_reg   <= evict_next;
            ins_reg     <= ins_next;
            removed_reg <= removed_next;
            nsurv_reg   <= nsurv_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_MAX_ENTRIES:    max_entries_reg <= cfg_wdata[10:0];
                    REG_EXPIRE_TIMEOUT: timeout_reg     <= cfg_wdata;
                    default:            timeout_reg     <= timeout_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_opcode;
            key_reg  <= s_key_tag;
            data_reg <= s_data_in;
            now_reg  <= s_now_seconds;
            sidx_reg <= s_stat_index;
        end
        s1_idx_reg  <= s1_idx_next;
        s2_idx_reg  <= s2_idx_next;
        s2_word_reg <= s2_word_next;
        slot_reg    <= slot_next;
        hrank_reg   <= hrank_next;
        hval_reg    <= hval_next;
        cut_reg     <= cut_next;
        found_o_reg <= found_o_next;
        dout_o_reg  <= dout_o_next;
        ent_o_reg   <= ent_o_next;
        rem_o_reg   <= rem_o_next;
        sval_o_reg  <= sval_o_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_found         = found_o_reg;
    assign m_data_out      = dout_o_reg;
    assign m_entries_now   = ent_o_reg;
    assign m_removed_count = rem_o_reg;
    assign m_stat_value    = sval_o_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count32 <= 32'(CAPACITY))
        else $error("entry count above capacity");

    a_no_dup_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIND && match) |-> !hit_reg)
        else $error("key present in two entries");

    a_insert_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD && pass_end && op_reg == OP_SET && !hit_reg) |-> ins_reg)
        else $error("set found no free entry");

    a_set_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && op_reg == OP_SET && !hit_reg) |-> count32 <= lim32)
        else $error("insert left count above limit");

endmodule
